// File: rtl/d2i_pkg.sv
// Package with payload types, target codes and helpers for the double to integer converter.
package d2i_pkg;

  typedef enum logic [2:0] {
    OP_S8  = 3'd0,
    OP_U8  = 3'd1,
    OP_S16 = 3'd2,
    OP_U16 = 3'd3,
    OP_S32 = 3'd4,
    OP_U32 = 3'd5,
    OP_S64 = 3'd6,
    OP_U64 = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] value_bits;
  } in_t;

  typedef struct packed {
    logic [63:0] result;
    logic        saturated;
  } out_t;

  localparam logic [10:0] ExpAllOnes = 11'h7ff;
  localparam logic [10:0] ExpBias64  = 11'd1087;
  localparam logic [10:0] ExpInt     = 11'd1075;

  // Decoded operand after stage one.
  typedef struct packed {
    logic        is_nan;
    logic        huge;
    logic        neg;
    logic        is_signed;
    logic [1:0]  wsel;
    logic        left;
    logic [5:0]  sh;
    logic        tiny;
    logic [52:0] sig;
  } dec_t;

  // Aligned magnitude after stage two.
  typedef struct packed {
    logic        is_nan;
    logic        huge;
    logic        neg;
    logic        is_signed;
    logic [1:0]  wsel;
    logic [63:0] ipart;
    logic        frac;
  } aln_t;

  // Mask of a target width selected by wsel (8, 16, 32, 64 bits).
  function automatic logic [63:0] wmask(input logic [1:0] wsel);
    logic [63:0] m;
    case (wsel)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/d2i_decode.sv
// Stage one: unpacks the double and plans the alignment shift.
module d2i_decode (
  input  d2i_pkg::in_t  in_i,
  output d2i_pkg::dec_t dec_o
);

  logic [10:0] ef;
  logic [51:0] man;

  assign ef  = in_i.value_bits[62:52];
  assign man = in_i.value_bits[51:0];

  // Classify the exponent and compute the shift distance.
  always_comb begin
    logic [10:0] rsh;
    logic [10:0] lsh;
    rsh = d2i_pkg::ExpInt - ef;
    lsh = ef - d2i_pkg::ExpInt;
    dec_o.is_nan    = (ef == d2i_pkg::ExpAllOnes) && (man != '0);
    dec_o.huge      = (ef == d2i_pkg::ExpAllOnes) || (ef >= d2i_pkg::ExpBias64);
    dec_o.neg       = in_i.value_bits[63];
    dec_o.is_signed = ~in_i.op[0];
    dec_o.wsel      = in_i.op[2:1];
    dec_o.left      = ef >= d2i_pkg::ExpInt;
    dec_o.sig       = (ef == '0) ? {1'b0, man} : {1'b1, man};
    dec_o.tiny      = 1'b0;
    dec_o.sh        = '0;
    if (dec_o.left) begin
      dec_o.sh = lsh[5:0];
    end else if (ef == '0 || rsh >= 11'd64) begin
      dec_o.tiny = 1'b1;
    end else begin
      dec_o.sh = rsh[5:0];
    end
  end

endmodule

// File: rtl/d2i_align.sv
// Stage two: shifts the significand to the integer point and finds any fraction.
module d2i_align (
  input  d2i_pkg::dec_t dec_i,
  output d2i_pkg::aln_t aln_o
);

  logic [63:0] sig_w;
  logic [63:0] lmask;

  assign sig_w = {11'd0, dec_i.sig};
  assign lmask = ~(64'hffff_ffff_ffff_ffff << dec_i.sh);

  always_comb begin
    aln_o.is_nan    = dec_i.is_nan;
    aln_o.huge      = dec_i.huge;
    aln_o.neg       = dec_i.neg;
    aln_o.is_signed = dec_i.is_signed;
    aln_o.wsel      = dec_i.wsel;
    if (dec_i.huge) begin
      aln_o.ipart = '0;
      aln_o.frac  = 1'b0;
    end else if (dec_i.tiny) begin
      aln_o.ipart = '0;
      aln_o.frac  = dec_i.sig != '0;
    end else if (dec_i.left) begin
      aln_o.ipart = sig_w << dec_i.sh;
      aln_o.frac  = 1'b0;
    end else begin
      aln_o.ipart = sig_w >> dec_i.sh;
      aln_o.frac  = (sig_w & lmask) != '0;
    end
  end

endmodule

// File: rtl/d2i_clamp.sv
// Stage three: compares against the target bounds and forms the result.
module d2i_clamp (
  input  d2i_pkg::aln_t aln_i,
  output d2i_pkg::out_t out_o
);

  logic [63:0] mask;
  logic [63:0] maxv;
  logic [63:0] minmag;
  logic        over;

  assign mask   = d2i_pkg::wmask(aln_i.wsel);
  assign maxv   = aln_i.is_signed ? (mask >> 1) : mask;
  assign minmag = aln_i.is_signed ? ((mask >> 1) + 64'd1) : '0;

  // Saturation check and result selection.
  always_comb begin
    if (!aln_i.neg) begin
      over = aln_i.huge || (aln_i.ipart > maxv) || (aln_i.ipart == maxv && aln_i.frac);
    end else if (aln_i.is_signed) begin
      over = aln_i.huge || (aln_i.ipart > minmag) || (aln_i.ipart == minmag && aln_i.frac);
    end else begin
      over = aln_i.huge || (aln_i.ipart != '0) || aln_i.frac;
    end
    if (aln_i.is_nan) begin
      out_o.result    = '0;
      out_o.saturated = 1'b1;
    end else if (over) begin
      out_o.result    = aln_i.neg ? (minmag & mask) : maxv;
      out_o.saturated = 1'b1;
    end else begin
      out_o.result    = (aln_i.neg ? (64'd0 - aln_i.ipart) : aln_i.ipart) & mask;
      out_o.saturated = 1'b0;
    end
  end

endmodule

// File: rtl/double_to_int_saturating_top.sv
// Top level: three-stage saturating double to integer conversion pipeline.
// Each input beat is registered after decode, after align and after clamp before it reaches the output.
// Throughput: one beat per cycle while out_ready_i holds; the decode, align and clamp stages each hold one item.
// A stage advances when its successor is empty or moving, so stalls lose nothing.
// Reset (rst_ni low, asynchronous) clears the stage valid bits; payload registers are not reset.
module double_to_int_saturating_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  d2i_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output d2i_pkg::out_t out_data_o
);

  d2i_pkg::dec_t dec_d, dec_q;
  d2i_pkg::aln_t aln_d, aln_q;
  d2i_pkg::out_t res_d, res_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  d2i_decode u_decode (.in_i(in_data_i), .dec_o(dec_d));
  d2i_align  u_align  (.dec_i(dec_q), .aln_o(aln_d));
  d2i_clamp  u_clamp  (.aln_i(aln_q), .out_o(res_d));

  // Stall control, back to front.
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en1) dec_q <= dec_d;
    if (en2) aln_q <= aln_d;
    if (en3) res_q <= res_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = res_q;

endmodule

// File: bench/double_to_int_saturating_top_test.sv
// Self-checking bench for the saturating double to integer converter.
module double_to_int_saturating_top_test;

  localparam int unsigned NumRandom = 1800;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  d2i_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  d2i_pkg::out_t out_data_o;

  double_to_int_saturating_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  d2i_pkg::out_t conversions_due[$];
  int unsigned errors = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned saturated_seen = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off = 0;

  // Bit-exact conversion of a binary64 pattern to the selected integer type.
  function automatic d2i_pkg::out_t convert_double(input d2i_pkg::op_e op,
                                                   input logic [63:0] bits);
    d2i_pkg::out_t r;
    int unsigned w;
    logic sgn, neg, frac, huge, over;
    logic [10:0] ef;
    logic [51:0] man;
    logic [52:0] sig;
    logic [63:0] mask, ipart, maxv, minmag, lowbits;
    int unsigned sh;
    w = 8 << (op >> 1);
    sgn = (op[0] == 1'b0);
    neg = bits[63];
    ef = bits[62:52];
    man = bits[51:0];
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    ipart = '0;
    frac = 1'b0;
    huge = 1'b0;
    if (ef == 11'h7ff && man != '0) begin
      r.result = '0;
      r.saturated = 1'b1;
      return r;
    end
    if (ef == 11'h7ff) begin
      huge = 1'b1;
    end else if (ef == 11'd0) begin
      frac = (man != '0);
    end else if (ef >= 11'd1087) begin
      huge = 1'b1;
    end else begin
      sig = {1'b1, man};
      if (ef >= 11'd1075) begin
        ipart = {11'd0, sig} << (ef - 11'd1075);
      end else begin
        sh = 1075 - ef;
        if (sh >= 64) begin
          frac = 1'b1;
        end else begin
          ipart = {11'd0, sig} >> sh;
          lowbits = (64'd1 << sh) - 64'd1;
          frac = (({11'd0, sig} & lowbits) != '0);
        end
      end
    end
    maxv = sgn ? ((64'd1 << (w - 1)) - 64'd1) : mask;
    minmag = sgn ? (64'd1 << (w - 1)) : '0;
    if (!neg) begin
      over = huge || ipart > maxv || (ipart == maxv && frac);
      r.result = over ? maxv : (ipart & mask);
    end else begin
      if (sgn) over = huge || ipart > minmag || (ipart == minmag && frac);
      else over = huge || ipart != '0 || frac;
      r.result = over ? (minmag & mask) : ((64'd0 - ipart) & mask);
    end
    r.saturated = over;
    return r;
  endfunction

  // Directed rows; a check flag marks rows with a typed-in result.
  typedef struct {
    d2i_pkg::op_e op;
    logic [63:0] bits;
    logic typed;
    logic [63:0] result;
    logic sat;
  } vec_t;

  vec_t directed[$] = '{
    '{d2i_pkg::OP_S8,  64'h0000_0000_0000_0000, 1'b1, 64'h0, 1'b0},
    '{d2i_pkg::OP_U64, 64'h8000_0000_0000_0000, 1'b1, 64'h0, 1'b0},
    '{d2i_pkg::OP_S64, 64'h7ff8_0000_0000_0000, 1'b1, 64'h0, 1'b1},
    '{d2i_pkg::OP_U8,  64'hfff0_0000_0000_0001, 1'b1, 64'h0, 1'b1},
    '{d2i_pkg::OP_S8,  64'h7ff0_0000_0000_0000, 1'b1, 64'h7f, 1'b1},
    '{d2i_pkg::OP_S8,  64'hfff0_0000_0000_0000, 1'b1, 64'h80, 1'b1},
    '{d2i_pkg::OP_U16, 64'h7ff0_0000_0000_0000, 1'b1, 64'hffff, 1'b1},
    '{d2i_pkg::OP_U32, 64'hfff0_0000_0000_0000, 1'b1, 64'h0, 1'b1},
    '{d2i_pkg::OP_S8,  64'h405f_c000_0000_0000, 1'b1, 64'h7f, 1'b0},
    '{d2i_pkg::OP_S8,  64'h405f_e000_0000_0000, 1'b1, 64'h7f, 1'b1},
    '{d2i_pkg::OP_U8,  64'hbfe0_0000_0000_0000, 1'b1, 64'h0, 1'b1},
    '{d2i_pkg::OP_S64, 64'hc3e0_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000, 1'b0},
    '{d2i_pkg::OP_S64, 64'h43e0_0000_0000_0000, 1'b1, 64'h7fff_ffff_ffff_ffff, 1'b1},
    '{d2i_pkg::OP_U64, 64'h43f0_0000_0000_0000, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1},
    '{d2i_pkg::OP_S16, 64'h0000_0000_0000_0001, 1'b1, 64'h0, 1'b0},
    '{d2i_pkg::OP_U16, 64'h800f_ffff_ffff_ffff, 1'b1, 64'h0, 1'b1},
    '{d2i_pkg::OP_S32, 64'hc1e0_0000_0000_0000, 1'b1, 64'h8000_0000, 1'b0},
    '{d2i_pkg::OP_S16, 64'hc0bf_3980_0000_0000, 1'b0, 64'h0, 1'b0},
    '{d2i_pkg::OP_U32, 64'h41ef_ffff_ffe0_0000, 1'b0, 64'h0, 1'b0},
    '{d2i_pkg::OP_U64, 64'h43ef_ffff_ffff_ffff, 1'b0, 64'h0, 1'b0},
    '{d2i_pkg::OP_S32, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0, 1'b0},
    '{d2i_pkg::OP_U8,  64'h7fef_ffff_ffff_ffff, 1'b0, 64'h0, 1'b0},
    '{d2i_pkg::OP_S64, 64'hc00c_0000_0000_0000, 1'b0, 64'h0, 1'b0}
  };

  // Random operand: mostly exponents near the integer range of the target.
  function automatic d2i_pkg::in_t random_operand();
    d2i_pkg::in_t it;
    int unsigned k;
    it.op = 3'($urandom_range(0, 7));
    it.value_bits = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    if (k < 7) begin
      it.value_bits[62:52] = 11'($urandom_range(1015, 1090));
    end else if (k == 7) begin
      it.value_bits[62:52] = ($urandom_range(0, 1) == 0) ? 11'h7ff : 11'h000;
      if ($urandom_range(0, 2) == 0) it.value_bits[51:0] = '0;
    end
    // Trim the low mantissa at times to hit exact integers.
    if ($urandom_range(0, 3) == 0) it.value_bits[31:0] = '0;
    return it;
  endfunction

  // Offer one beat, holding it until accepted; valid drops only while idling.
  task automatic send_beat(input d2i_pkg::in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Predictor side: every accepted input beat queues its conversion.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      conversions_due.push_back(convert_double(d2i_pkg::op_e'(in_data_i.op),
                                               in_data_i.value_bits));
      beats_in++;
    end
  end

  // Output check against the oldest pending conversion.
  always @(posedge clk_i) begin
    d2i_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (out_data_o.saturated) saturated_seen++;
      if (conversions_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat result=%h saturated=%b", $time,
                 out_data_o.result, out_data_o.saturated);
      end else begin
        want = conversions_due.pop_front();
        if (want.result !== out_data_o.result) begin
          errors++;
          $display("%0t: result expected %h actual %h", $time, want.result,
                   out_data_o.result);
        end
        if (want.saturated !== out_data_o.saturated) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   out_data_o.saturated);
        end
      end
    end
  end

  // Receiver ready, with one long hold-off counted in cycles.
  always @(negedge clk_i) begin
    if (hold_off != 0) begin
      hold_off--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    d2i_pkg::in_t it;
    vec_t v;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows; typed-in results cross-check the predictor too.
    foreach (directed[i]) begin
      v = directed[i];
      if (v.typed) begin
        if (convert_double(v.op, v.bits) !== {v.result, v.sat}) begin
          errors++;
          $display("%0t: row %0d expected %h/%b actual %h/%b", $time, i, v.result, v.sat,
                   convert_double(v.op, v.bits).result,
                   convert_double(v.op, v.bits).saturated);
        end
      end
      it.op = v.op;
      it.value_bits = v.bits;
      send_beat(it);
    end

    // Random part in three idling phases, with a long hold-off in the first.
    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n == 0) begin
        send_idle_pct = 18;
        recv_idle_pct = 47;
      end else if (n == NumRandom / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 18;
      end else if (n == 2 * NumRandom / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 100) hold_off = 60;
      send_beat(random_operand());
    end
    in_valid_i <= 1'b0;

    while (conversions_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Converted %0d operands over all eight targets, %0d of them saturated or NaN.",
             beats_out, saturated_seen);
    if (errors == 0 && beats_in == beats_out) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
